>>> src/priority_layer_table_assert.svh
// ----------------------------------------------------------------------------
// priority_layer_table assertion macros
// concurrent checks clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef PRIORITY_LAYER_TABLE_ASSERT_SVH
`define PRIORITY_LAYER_TABLE_ASSERT_SVH

// same-cycle implication
`define PLT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// shared types, sizes and helpers of the priority layer table
// ----------------------------------------------------------------------------
package plt_pkg;

    localparam int NUM_SLOTS = 7;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int COORD_W   = 8;
    localparam int PRIO_W    = 8;
    localparam int ID_W      = 8;
    localparam int OUT_W     = 3;

    typedef logic [IDX_W-1:0] t_idx;

    localparam t_idx LAST_IDX = t_idx'(NUM_SLOTS - 1);

    typedef enum logic [1:0] {
        CMD_REQUEST,
        CMD_REPRIO,
        CMD_LOOKUP,
        CMD_NONE
    } t_cmd;

    typedef struct packed {
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_y;
        logic               used;
        logic [PRIO_W-1:0]  prio;
        t_idx               ident;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_idx   addr;
        t_entry data;
    } t_wr;

    typedef struct packed {
        logic gt;
        logic id_eq;
        logic free;
    } t_cmp;

    // zero-extend or truncate a slot index to the result field width
    function automatic logic [OUT_W-1:0] fit_out(input t_idx v);
        logic [IDX_W+OUT_W-1:0] wide;
        wide = {{OUT_W{1'b0}}, v};
        return wide[OUT_W-1:0];
    endfunction

endpackage

>>> src/plt_table.sv
// ----------------------------------------------------------------------------
// plt_table
// slot storage: one read port, one write port, identifiers reset to index
// ----------------------------------------------------------------------------
module plt_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  plt_pkg::t_idx  i_rd_addr,
    output plt_pkg::t_entry o_rd_data,
    input  plt_pkg::t_wr   i_wr
);

    plt_pkg::t_entry r_slot [plt_pkg::NUM_SLOTS];

    // empty slot whose identifier equals its index
    function automatic plt_pkg::t_entry reset_entry(input int k);
        plt_pkg::t_entry e;
        e       = '0;
        e.ident = plt_pkg::t_idx'(k);
        return e;
    endfunction

    assign o_rd_data = r_slot[i_rd_addr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < plt_pkg::NUM_SLOTS; k++) begin
                r_slot[k] <= reset_entry(k);
            end
        end else if (i_wr.en) begin
            r_slot[i_wr.addr] <= i_wr.data;
        end
    end

endmodule

>>> src/plt_cmp.sv
// ----------------------------------------------------------------------------
// plt_cmp
// shared compare unit: priority order, identifier match, free slot test
// ----------------------------------------------------------------------------
module plt_cmp (
    input  logic [plt_pkg::PRIO_W-1:0] i_a_prio,
    input  logic [plt_pkg::PRIO_W-1:0] i_b_prio,
    input  plt_pkg::t_entry            i_entry,
    input  logic [plt_pkg::ID_W-1:0]   i_layer_id,
    output plt_pkg::t_cmp              o_res
);

    logic [plt_pkg::ID_W-1:0] ident_ext;

    assign ident_ext   = {{(plt_pkg::ID_W - plt_pkg::IDX_W){1'b0}}, i_entry.ident};
    assign o_res.gt    = i_a_prio > i_b_prio;
    assign o_res.id_eq = ident_ext == i_layer_id;
    assign o_res.free  = !i_entry.used;

endmodule

>>> src/plt_ctrl.sv
// ----------------------------------------------------------------------------
// plt_ctrl
// command sequencer: slot scan, bubble-up and bubble-down passes, re-find
// ----------------------------------------------------------------------------
`include "priority_layer_table_assert.svh"

module plt_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [1:0]                  i_cmd,
    input  logic [plt_pkg::ID_W-1:0]    i_layer_id,
    input  logic [plt_pkg::PRIO_W-1:0]  i_priority_req,
    input  logic [plt_pkg::COORD_W-1:0] i_min_x,
    input  logic [plt_pkg::COORD_W-1:0] i_max_x,
    input  logic [plt_pkg::COORD_W-1:0] i_min_y,
    input  logic [plt_pkg::COORD_W-1:0] i_max_y,
    output logic                        o_busy,
    output logic                        o_valid,
    output logic [plt_pkg::OUT_W-1:0]   o_granted_id,
    output logic                        o_granted,
    output logic [plt_pkg::OUT_W-1:0]   o_position,
    output logic                        o_found,
    output plt_pkg::t_idx               o_rd_addr,
    input  plt_pkg::t_entry             i_rd_data,
    output plt_pkg::t_wr                o_wr,
    output logic [plt_pkg::PRIO_W-1:0]  o_cmp_a,
    output logic [plt_pkg::PRIO_W-1:0]  o_cmp_b,
    output logic [plt_pkg::ID_W-1:0]    o_cmp_id,
    input  plt_pkg::t_cmp               i_cmp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FIX0,
        S_UP,
        S_DOWN,
        S_DFIN,
        S_FIND
    } t_state;

    t_state                        r_state, n_state;
    plt_pkg::t_cmd                 r_cmd, n_cmd;
    logic [plt_pkg::ID_W-1:0]      r_id, n_id;
    logic [plt_pkg::PRIO_W-1:0]    r_prio, n_prio;
    logic [plt_pkg::COORD_W-1:0]   r_min_x, n_min_x;
    logic [plt_pkg::COORD_W-1:0]   r_max_x, n_max_x;
    logic [plt_pkg::COORD_W-1:0]   r_min_y, n_min_y;
    logic [plt_pkg::COORD_W-1:0]   r_max_y, n_max_y;
    plt_pkg::t_idx                 r_j, n_j;
    plt_pkg::t_entry               r_carry, n_carry;
    plt_pkg::t_idx                 r_gid, n_gid;
    logic                          r_granted, n_granted;
    plt_pkg::t_idx                 r_pos, n_pos;
    logic                          r_hit, n_hit;
    logic                          r_valid, n_valid;
    logic                          match;
    plt_pkg::t_entry               upd;

    assign o_busy       = r_state != S_IDLE;
    assign o_valid      = r_valid;
    assign o_granted_id = plt_pkg::fit_out(r_gid);
    assign o_granted    = r_granted;
    assign o_position   = plt_pkg::fit_out(r_pos);
    assign o_found      = r_hit;
    assign o_cmp_id     = r_id;

    assign match = (r_cmd == plt_pkg::CMD_REQUEST) ? i_cmp.free : i_cmp.id_eq;

    always_comb begin
        upd      = i_rd_data;
        upd.prio = r_prio;
    end

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_id      = r_id;
        n_prio    = r_prio;
        n_min_x   = r_min_x;
        n_max_x   = r_max_x;
        n_min_y   = r_min_y;
        n_max_y   = r_max_y;
        n_j       = r_j;
        n_carry   = r_carry;
        n_gid     = r_gid;
        n_granted = r_granted;
        n_pos     = r_pos;
        n_hit     = r_hit;
        n_valid   = 1'b0;
        o_rd_addr = r_j;
        o_wr      = '0;
        // bubble-up: lower carry against upper entry; bubble-down: the reverse
        o_cmp_a   = (r_state == S_DOWN) ? i_rd_data.prio : r_carry.prio;
        o_cmp_b   = (r_state == S_DOWN) ? r_carry.prio : i_rd_data.prio;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd     = plt_pkg::t_cmd'(i_cmd);
                    n_id      = i_layer_id;
                    n_prio    = i_priority_req;
                    n_min_x   = i_min_x;
                    n_max_x   = i_max_x;
                    n_min_y   = i_min_y;
                    n_max_y   = i_max_y;
                    n_j       = '0;
                    n_gid     = '0;
                    n_granted = 1'b0;
                    n_pos     = '0;
                    n_hit     = 1'b0;
                    if (plt_pkg::t_cmd'(i_cmd) == plt_pkg::CMD_NONE) begin
                        n_valid = 1'b1;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (match) begin
                    case (r_cmd)
                        plt_pkg::CMD_REQUEST: begin
                            o_wr.en         = 1'b1;
                            o_wr.addr       = r_j;
                            o_wr.data.min_x = r_min_x;
                            o_wr.data.max_x = r_max_x;
                            o_wr.data.min_y = r_min_y;
                            o_wr.data.max_y = r_max_y;
                            o_wr.data.used  = 1'b1;
                            o_wr.data.prio  = r_prio;
                            o_wr.data.ident = i_rd_data.ident;
                            n_gid           = i_rd_data.ident;
                            n_granted       = 1'b1;
                            n_j             = plt_pkg::LAST_IDX;
                            n_state         = S_UP;
                        end
                        plt_pkg::CMD_REPRIO: begin
                            o_wr.en   = 1'b1;
                            o_wr.addr = r_j;
                            o_wr.data = upd;
                            n_hit     = 1'b1;
                            n_j       = plt_pkg::LAST_IDX;
                            n_state   = S_UP;
                        end
                        default: begin
                            n_hit   = 1'b1;
                            n_pos   = r_j;
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                    endcase
                end else if (r_j == plt_pkg::LAST_IDX) begin
                    // absent identifier: reprioritize falls back to the top entry
                    if (r_cmd == plt_pkg::CMD_REPRIO) begin
                        n_state = S_FIX0;
                    end else begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_FIX0: begin
                o_rd_addr = '0;
                o_wr.en   = 1'b1;
                o_wr.addr = '0;
                o_wr.data = upd;
                n_j       = plt_pkg::LAST_IDX;
                n_state   = S_UP;
            end
            S_UP: begin
                if (r_j == plt_pkg::LAST_IDX) begin
                    n_carry = i_rd_data;
                    n_j     = r_j - 1'b1;
                end else begin
                    o_wr.en   = 1'b1;
                    o_wr.addr = r_j + 1'b1;
                    if (i_cmp.gt) begin
                        o_wr.data = i_rd_data;
                    end else begin
                        o_wr.data = r_carry;
                        n_carry   = i_rd_data;
                    end
                    if (r_j == '0) begin
                        n_j     = plt_pkg::t_idx'(1);
                        n_state = S_DOWN;
                    end else begin
                        n_j = r_j - 1'b1;
                    end
                end
            end
            S_DOWN: begin
                o_wr.en   = 1'b1;
                o_wr.addr = r_j - 1'b1;
                if (i_cmp.gt) begin
                    o_wr.data = i_rd_data;
                end else begin
                    o_wr.data = r_carry;
                    n_carry   = i_rd_data;
                end
                if (r_j == plt_pkg::LAST_IDX) begin
                    n_state = S_DFIN;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_DFIN: begin
                o_wr.en   = 1'b1;
                o_wr.addr = plt_pkg::LAST_IDX;
                o_wr.data = r_carry;
                if (r_cmd == plt_pkg::CMD_REPRIO && r_hit) begin
                    n_j     = '0;
                    n_state = S_FIND;
                end else begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FIND: begin
                if (i_cmp.id_eq) begin
                    n_pos = r_j;
                end
                if (i_cmp.id_eq || r_j == plt_pkg::LAST_IDX) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= 1'b0;
            r_granted <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_granted <= n_granted;
            r_hit     <= n_hit;
        end
        r_cmd   <= n_cmd;
        r_id    <= n_id;
        r_prio  <= n_prio;
        r_min_x <= n_min_x;
        r_max_x <= n_max_x;
        r_min_y <= n_min_y;
        r_max_y <= n_max_y;
        r_j     <= n_j;
        r_carry <= n_carry;
        r_gid   <= n_gid;
        r_pos   <= n_pos;
    end

    `PLT_ASSERT_NOW(a_strobe_idle, r_valid, r_state == S_IDLE, "result strobe while busy")
    `PLT_ASSERT_NEXT(a_start_moves, i_start && r_state == S_IDLE, o_busy || r_valid, "request dropped")
    `PLT_ASSERT_NOW(a_grant_excl, r_valid && r_granted, !r_hit && r_cmd == plt_pkg::CMD_REQUEST, "grant on non-request")
    `PLT_ASSERT_NOW(a_pos_found, r_valid && !r_hit, r_pos == '0, "position without a match")

endmodule

>>> src/priority_layer_table.sv
// ----------------------------------------------------------------------------
// priority_layer_table
// table of display layers kept in stable descending priority order
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the result (command 3 never raises busy). The result is flagged by
// o_valid high for exactly one cycle and cannot be held off. All work
// goes through one compare unit and a one-read, one-write slot table, one
// slot per cycle. Lookup scans up to the match or the last slot; request
// scans for a free slot, writes it and runs the bubble-up and bubble-down
// sort passes (none when the table is full); reprioritize runs the scan,
// the sort passes and, when the identifier was found, a re-find. Each then
// strobes the result. Command 3 strobes in the next cycle.
module priority_layer_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_cmd,
    input  logic [plt_pkg::ID_W-1:0]    i_layer_id,
    input  logic [plt_pkg::PRIO_W-1:0]  i_priority_req,
    input  logic [plt_pkg::COORD_W-1:0] i_min_x,
    input  logic [plt_pkg::COORD_W-1:0] i_max_x,
    input  logic [plt_pkg::COORD_W-1:0] i_min_y,
    input  logic [plt_pkg::COORD_W-1:0] i_max_y,
    output logic                        o_valid,
    output logic [plt_pkg::OUT_W-1:0]   o_granted_id,
    output logic                        o_granted,
    output logic [plt_pkg::OUT_W-1:0]   o_position,
    output logic                        o_found
);

    plt_pkg::t_idx              rd_addr;
    plt_pkg::t_entry            rd_data;
    plt_pkg::t_wr               wr;
    logic [plt_pkg::PRIO_W-1:0] cmp_a;
    logic [plt_pkg::PRIO_W-1:0] cmp_b;
    logic [plt_pkg::ID_W-1:0]   cmp_id;
    plt_pkg::t_cmp              cmp_res;

    plt_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr      (wr)
    );

    plt_cmp u_cmp (
        .i_a_prio   (cmp_a),
        .i_b_prio   (cmp_b),
        .i_entry    (rd_data),
        .i_layer_id (cmp_id),
        .o_res      (cmp_res)
    );

    plt_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_cmd          (i_cmd),
        .i_layer_id     (i_layer_id),
        .i_priority_req (i_priority_req),
        .i_min_x        (i_min_x),
        .i_max_x        (i_max_x),
        .i_min_y        (i_min_y),
        .i_max_y        (i_max_y),
        .o_busy         (busy),
        .o_valid        (o_valid),
        .o_granted_id   (o_granted_id),
        .o_granted      (o_granted),
        .o_position     (o_position),
        .o_found        (o_found),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_wr           (wr),
        .o_cmp_a        (cmp_a),
        .o_cmp_b        (cmp_b),
        .o_cmp_id       (cmp_id),
        .i_cmp          (cmp_res)
    );

endmodule
